@@ src/ept_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ept_pkg
// Shared constants, types and fixed-point helpers for the pose-to-transform
// block.
// ----------------------------------------------------------------------------
package ept_pkg;

   localparam int ANGLE_WIDTH     = 16;
   localparam int VALUE_FRAC_BITS = 16;
   localparam int OUT_SHIFT       = 30 - VALUE_FRAC_BITS;

   typedef logic signed [31:0] q30_type;
   typedef logic signed [63:0] prod_type;

   localparam q30_type Q30_ONE = 32'sh4000_0000;
   localparam logic signed [31:0] OUT_ONE = 32'sd1 <<< VALUE_FRAC_BITS;

   localparam q30_type COEF0 = 32'sd1686629713;
   localparam q30_type COEF1 = -32'sd693598668;
   localparam q30_type COEF2 = 32'sd85569306;
   localparam q30_type COEF3 = -32'sd5026995;
   localparam q30_type COEF4 = 32'sd172272;
   localparam q30_type COEF5 = -32'sd3864;

   // Round to nearest, halves away from zero, then drop k bits.
   function automatic prod_type round_shift(input prod_type v, input int k);
      logic [63:0] m;
      logic [63:0] half;
      begin
         half = 64'd1 << (k - 1);
         m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
         m = (m + half) >> k;
         round_shift = v[63] ? -prod_type'(m) : prod_type'(m);
      end
   endfunction

   // Product of two Q30 values, rounded back to Q30.
   function automatic q30_type mul_q30(input q30_type a, input q30_type b);
      prod_type p;
      prod_type r;
      begin
         p = prod_type'(a) * prod_type'(b);
         r = round_shift(p, 30);
         mul_q30 = r[31:0];
      end
   endfunction

   function automatic logic [31:0] to_out(input q30_type v);
      prod_type r;
      begin
         r = round_shift(prod_type'(v), OUT_SHIFT);
         to_out = r[31:0];
      end
   endfunction

   function automatic logic [31:0] angle_phase(input logic [15:0] f);
      logic [31:0] v;
      begin
         v = {{16{f[15]}}, f};
         angle_phase = v << (32 - ANGLE_WIDTH);
      end
   endfunction

   typedef struct packed {
      logic        three_d;
      logic [31:0] tx;
      logic [31:0] ty;
      logic [31:0] tz;
   } side_type;

endpackage

@@ src/ept_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ept_req_if / ept_rsp_if
// Valid/ready channels for pose words and matrix row words.
// ----------------------------------------------------------------------------
interface ept_req_if;
   logic               valid;
   logic               ready;
   logic               three_d;
   logic signed [31:0] trans_x;
   logic signed [31:0] trans_y;
   logic signed [31:0] trans_z;
   logic signed [15:0] angle_first;
   logic signed [15:0] angle_second;
   logic signed [15:0] angle_third;
   modport source (output valid, three_d, trans_x, trans_y, trans_z,
                   angle_first, angle_second, angle_third, input ready);
   modport sink (input valid, three_d, trans_x, trans_y, trans_z,
                 angle_first, angle_second, angle_third, output ready);
endinterface

interface ept_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         row_index;
   logic signed [31:0] elem_c0;
   logic signed [31:0] elem_c1;
   logic signed [31:0] elem_c2;
   logic signed [31:0] elem_c3;
   logic               last_row;
   modport source (output valid, row_index, elem_c0, elem_c1, elem_c2, elem_c3,
                   last_row, input ready);
   modport sink (input valid, row_index, elem_c0, elem_c1, elem_c2, elem_c3,
                 last_row, output ready);
endinterface

@@ src/ept_sine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ept_sine
// Pipelined Q30 sine: fold, square, one Horner step per stage, then times x; 8 stages, enable-stalled.
// ----------------------------------------------------------------------------
module ept_sine (
   input  logic                 clock,
   input  logic                 en,
   input  logic [31:0]          phase,
   output ept_pkg::q30_type     sine
);
   import ept_pkg::*;

   // stage 0: fold; stage 1: square
   logic [1:0] q_ff [0:7];
   q30_type    x_ff [0:6];
   q30_type    z_ff [1:5];
   q30_type    acc_ff [2:7];
   q30_type    x_in;
   q30_type    res;
   q30_type    coef [0:3];

   assign coef[0] = COEF0;
   assign coef[1] = COEF1;
   assign coef[2] = COEF2;
   assign coef[3] = COEF3;

   always_comb begin
      x_in = phase[30] ? (Q30_ONE - q30_type'({2'b00, phase[29:0]}))
                       : q30_type'({2'b00, phase[29:0]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff[0] <= phase[31:30];
         x_ff[0] <= x_in;
         q_ff[1] <= q_ff[0];
         x_ff[1] <= x_ff[0];
         z_ff[1] <= mul_q30(x_ff[0], x_ff[0]);
         q_ff[2] <= q_ff[1];
         x_ff[2] <= x_ff[1];
         z_ff[2] <= z_ff[1];
         acc_ff[2] <= COEF4 + mul_q30(COEF5, z_ff[1]);
         for (int i = 3; i <= 6; i++) begin
            q_ff[i] <= q_ff[i-1];
            x_ff[i] <= x_ff[i-1];
            acc_ff[i] <= coef[6-i] + mul_q30(acc_ff[i-1], z_ff[i-1]);
         end
         for (int i = 3; i <= 5; i++) z_ff[i] <= z_ff[i-1];
         // last stage: odd polynomial, times x
         q_ff[7] <= q_ff[6];
         acc_ff[7] <= mul_q30(acc_ff[6], x_ff[6]);
      end
   end

   always_comb begin
      res = acc_ff[7];
      if (res < 0) res = '0;
      if (res > Q30_ONE) res = Q30_ONE;
      sine = q_ff[7][1] ? -res : res;
   end
endmodule

@@ src/euler_pose_to_transform_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_pose_to_transform_matrix
// Euler pose to homogeneous transform, one matrix row per output word.
// ----------------------------------------------------------------------------
// Path: pose word to first row word runs through 8 sine stages, the sine
//   register, 2 product stages, rounding, sequencer load and output register.
// Throughput: one row word per cycle while rsp.ready holds; a pose gives 3 (planar)
//   or 4 (spatial) row words, from the row sequencer that feeds the one output register.
// Reset: synchronous, clears all valid bits and the row counter.
// ----------------------------------------------------------------------------
module euler_pose_to_transform_matrix (
   input logic clock,
   input logic reset,
   ept_req_if.sink   req,
   ept_rsp_if.source rsp
);
   import ept_pkg::*;

   localparam int NSTG = 12; // pipeline stages before the row sequencer

   // pipeline advances when the sequencer takes a new pose or the last stage is empty
   logic adv;
   logic [NSTG-1:0] vld_ff;
   side_type side_ff [0:NSTG-1];

   // sine/cosine of three angles
   q30_type s1, c1, s2, c2, s3, c3;
   logic [31:0] p1, p2, p3;
   assign p1 = angle_phase(req.angle_first);
   assign p2 = angle_phase(req.angle_second);
   assign p3 = angle_phase(req.angle_third);

   ept_sine u_s1 (.clock(clock), .en(adv), .phase(p1), .sine(s1));
   ept_sine u_c1 (.clock(clock), .en(adv), .phase(p1 + 32'h4000_0000), .sine(c1));
   ept_sine u_s2 (.clock(clock), .en(adv), .phase(p2), .sine(s2));
   ept_sine u_c2 (.clock(clock), .en(adv), .phase(p2 + 32'h4000_0000), .sine(c2));
   ept_sine u_s3 (.clock(clock), .en(adv), .phase(p3), .sine(s3));
   ept_sine u_c3 (.clock(clock), .en(adv), .phase(p3 + 32'h4000_0000), .sine(c3));

   // stage 8: registered trig values
   q30_type s1_ff, c1_ff, s2_ff, c2_ff, s3_ff, c3_ff;
   // stage 9: first-level products
   q30_type c3c1_ff, s1s3_ff, c3s1_ff, c1c2_ff, c1s3_ff, s1c2_ff;
   q30_type e02_ff, e12_ff, e20_ff, e21_ff, p_c2_ff, p_s3_ff, p_s1_ff, p_c1_ff;
   q30_type p_c2b_ff;
   // stage 10: entries in Q30
   q30_type e00_ff, e01_ff, e10_ff, e11_ff, f02_ff, f12_ff, f20_ff, f21_ff;
   q30_type g_s1_ff, g_c1_ff, g_c2_ff;
   // stage 11: rounded row words
   logic [31:0] o00_ff, o01_ff, o02_ff, o10_ff, o11_ff, o12_ff, o20_ff, o21_ff;
   logic [31:0] o22_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= '{three_d: req.three_d, tx: req.trans_x, ty: req.trans_y,
                         tz: req.trans_z};
         for (int i = 1; i < NSTG; i++) side_ff[i] <= side_ff[i-1];
         s1_ff <= s1; c1_ff <= c1; s2_ff <= s2;
         c2_ff <= c2; s3_ff <= s3; c3_ff <= c3;
         c3c1_ff <= mul_q30(c3_ff, c1_ff);
         s1s3_ff <= mul_q30(s1_ff, s3_ff);
         c3s1_ff <= mul_q30(c3_ff, s1_ff);
         c1c2_ff <= mul_q30(c1_ff, c2_ff);
         c1s3_ff <= mul_q30(c1_ff, s3_ff);
         s1c2_ff <= mul_q30(s1_ff, c2_ff);
         e02_ff  <= -mul_q30(s2_ff, c1_ff);
         e12_ff  <= -mul_q30(s2_ff, s1_ff);
         e20_ff  <= mul_q30(s2_ff, c3_ff);
         e21_ff  <= -mul_q30(s2_ff, s3_ff);
         p_c2_ff <= c2_ff;
         p_c2b_ff <= c2_ff;
         p_s3_ff <= s3_ff;
         p_s1_ff <= s1_ff;
         p_c1_ff <= c1_ff;
         e00_ff <= mul_q30(c3c1_ff, p_c2_ff) - s1s3_ff;
         e01_ff <= -c3s1_ff - mul_q30(c1c2_ff, p_s3_ff);
         e10_ff <= c1s3_ff + mul_q30(c3s1_ff, p_c2_ff);
         e11_ff <= c3c1_ff - mul_q30(s1c2_ff, p_s3_ff);
         f02_ff <= e02_ff; f12_ff <= e12_ff; f20_ff <= e20_ff; f21_ff <= e21_ff;
         g_s1_ff <= p_s1_ff; g_c1_ff <= p_c1_ff; g_c2_ff <= p_c2b_ff;
         // planar mode picks c1/s1 directly
         if (side_ff[10].three_d) begin
            o00_ff <= to_out(e00_ff); o01_ff <= to_out(e01_ff);
            o02_ff <= to_out(f02_ff);
            o10_ff <= to_out(e10_ff); o11_ff <= to_out(e11_ff);
            o12_ff <= to_out(f12_ff);
         end else begin
            o00_ff <= to_out(g_c1_ff); o01_ff <= to_out(-g_s1_ff);
            o02_ff <= side_ff[10].tx;
            o10_ff <= to_out(g_s1_ff); o11_ff <= to_out(g_c1_ff);
            o12_ff <= side_ff[10].ty;
         end
         o20_ff <= to_out(f20_ff); o21_ff <= to_out(f21_ff);
         o22_ff <= to_out(g_c2_ff);
      end
   end

   // row sequencer with one output register
   logic [1:0] row_ff, row_in;
   logic       busy_ff, busy_in;
   side_type   cur_ff;
   logic [31:0] r00_ff, r01_ff, r02_ff, r10_ff, r11_ff, r12_ff;
   logic [31:0] r20_ff, r21_ff, r22_ff;
   logic        out_vld_ff;
   logic        last_now, take, load;

   assign take     = rsp.ready || !out_vld_ff;
   assign last_now = cur_ff.three_d ? (row_ff == 2'd3) : (row_ff == 2'd2);
   assign load     = take && (!busy_ff || last_now);
   assign adv      = load || !vld_ff[NSTG-1];
   // no pose word taken while reset is high
   assign req.ready = adv && !reset;

   always_comb begin
      row_in  = row_ff;
      busy_in = busy_ff;
      if (take && busy_ff) row_in = row_ff + 2'd1;
      if (load) begin
         busy_in = vld_ff[NSTG-1];
         row_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         row_ff     <= '0;
         busy_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (adv) vld_ff <= {vld_ff[NSTG-2:0], req.valid};
         row_ff  <= row_in;
         busy_ff <= busy_in;
         if (take) out_vld_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= side_ff[NSTG-1];
         r00_ff <= o00_ff; r01_ff <= o01_ff; r02_ff <= o02_ff;
         r10_ff <= o10_ff; r11_ff <= o11_ff; r12_ff <= o12_ff;
         r20_ff <= o20_ff; r21_ff <= o21_ff; r22_ff <= o22_ff;
      end
      if (take && busy_ff) begin
         rsp.row_index <= row_ff;
         rsp.last_row  <= last_now;
         unique case (row_ff)
            2'd0: begin
               rsp.elem_c0 <= r00_ff; rsp.elem_c1 <= r01_ff;
               rsp.elem_c2 <= r02_ff;
               rsp.elem_c3 <= cur_ff.three_d ? cur_ff.tx : '0;
            end
            2'd1: begin
               rsp.elem_c0 <= r10_ff; rsp.elem_c1 <= r11_ff;
               rsp.elem_c2 <= r12_ff;
               rsp.elem_c3 <= cur_ff.three_d ? cur_ff.ty : '0;
            end
            2'd2: begin
               rsp.elem_c0 <= cur_ff.three_d ? r20_ff : '0;
               rsp.elem_c1 <= cur_ff.three_d ? r21_ff : '0;
               rsp.elem_c2 <= cur_ff.three_d ? r22_ff : OUT_ONE;
               rsp.elem_c3 <= cur_ff.three_d ? cur_ff.tz : '0;
            end
            default: begin
               rsp.elem_c0 <= '0; rsp.elem_c1 <= '0;
               rsp.elem_c2 <= '0; rsp.elem_c3 <= OUT_ONE;
            end
         endcase
      end
   end

   assign rsp.valid = out_vld_ff;

   // sequencer only ever names rows 0..3 and planar stops at 2
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !cur_ff.three_d |-> row_ff != 2'd3)
      else $error("planar row overrun");
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.last_row |-> rsp.row_index == 2'd2 || rsp.row_index == 2'd3)
      else $error("last flag on early row");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp.ready |=> out_vld_ff)
      else $error("output word dropped");
endmodule
